/* src/ois_pkg.sv */
// ----------------------------------------------------------------------------
// ois_pkg
// Shared types for the ordered integer set: item and result payloads,
// operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ois_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic       success;
        logic       full_reject;
        logic [4:0] count;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } t_state;

endpackage

/* src/ois_store.sv */
// ----------------------------------------------------------------------------
// ois_store
// Member store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ois_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ois_ctrl.sv */
// ----------------------------------------------------------------------------
// ois_ctrl
// Sequencer: walks the store through its single read port, compares each
// member against the operand, appends on add and closes the gap on remove.
// ----------------------------------------------------------------------------
module ois_ctrl
    import ois_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_in           i_item,
    output logic          o_idle,
    output logic          o_done,
    output t_out          o_result,
    input  logic          i_take,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [31:0]   o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [31:0]   i_rdata
);

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [31:0]     r_value, n_value;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_pidx, n_pidx;
    logic            r_pend, n_pend;
    logic            r_success, n_success;
    logic            r_full, n_full;
    logic            found;
    logic [CW-1:0]   idx_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op      <= n_op;
        r_value   <= n_value;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_success <= n_success;
        r_full    <= n_full;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_value   = r_value;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_success = r_success;
        n_full    = r_full;
        o_idle    = 1'b0;
        o_done    = 1'b0;
        o_we      = 1'b0;
        o_waddr   = r_idx[AW-1:0];
        o_wdata   = r_value;
        o_raddr   = r_idx[AW-1:0];
        found     = r_pend && (i_rdata == r_value);
        idx_nxt   = r_idx + CW'(1);

        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_op      = i_item.operation;
                    n_value   = i_item.value;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_success = 1'b0;
                    n_full    = 1'b0;
                    if (i_item.operation == OP_CLEAR) begin
                        n_count   = '0;
                        n_success = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (found) begin
                    n_pend = 1'b0;
                    case (r_op)
                        OP_REMOVE: begin
                            n_idx   = r_pidx;
                            n_state = ST_SH_RD;
                        end
                        OP_LOOKUP: begin
                            n_success = 1'b1;
                            n_state   = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end else if (r_idx == r_count) begin
                    n_pend  = 1'b0;
                    n_state = ST_DONE;
                    if (r_op == OP_ADD) begin
                        if (r_count < CW'(DEPTH)) begin
                            o_we      = 1'b1;
                            o_waddr   = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                            n_success = 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                end else begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = idx_nxt;
                end
            end
            ST_SH_RD: begin
                if (idx_nxt < r_count) begin
                    o_raddr = idx_nxt[AW-1:0];
                    n_state = ST_SH_WR;
                end else begin
                    n_count   = r_count - CW'(1);
                    n_success = 1'b1;
                    n_state   = ST_DONE;
                end
            end
            ST_SH_WR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                n_idx   = idx_nxt;
                n_state = ST_SH_RD;
            end
            ST_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_result.success     = r_success;
    assign o_result.full_reject = r_full;
    assign o_result.count       = 5'(r_count);

endmodule

/* src/ordered_integer_set.sv */
// ----------------------------------------------------------------------------
// ordered_integer_set
// Clear finishes without touching the store; add and lookup walk the members
// (one store read per cycle through the single read port).
// Remove: after the match, each later entry is shifted down (read, write).
// Items are handled one at a time: the next item is taken the cycle
// after its result reaches the output register.
// Reset clears count and control, no sweep.
// ----------------------------------------------------------------------------
module ordered_integer_set
    import ois_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic          idle;
    logic          done;
    logic          take;
    t_out          result;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic          r_out_valid;
    t_out          r_out_data;

    ois_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_in_valid && idle),
        .i_item   (i_in_data),
        .o_idle   (idle),
        .o_done   (done),
        .o_result (result),
        .i_take   (take),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata)
    );

    ois_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (done && take) begin
            r_out_data <= result;
        end
    end

    assign o_in_ready  = idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/ois_checker.sv */
// ----------------------------------------------------------------------------
// ois_checker
// Port-level checks on the ordered integer set, bound to the top level.
// ----------------------------------------------------------------------------
module ois_checker
    import ois_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.full_reject |->
            !o_out_data.success && (o_out_data.count == 5'(DEPTH)))
        else $error("full reject with success or short count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (DEPTH > 31) || (o_out_data.count <= 5'(DEPTH)))
        else $error("count beyond capacity");

endmodule

bind ordered_integer_set ois_checker #(
    .DEPTH (DEPTH)
) u_ois_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
